// File: src/fvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, prime tables and the cosine ramp generator for the fractal
// value noise block.
// ----------------------------------------------------------------------------
package fvn_pkg;

    typedef enum logic [2:0] {
        REG_HASH_SELECT  = 3'd0,
        REG_PERSISTENCE  = 3'd1,
        REG_NUM_OCTAVES  = 3'd2,
        REG_RESOLUTION   = 3'd3,
        REG_RANGE_ENABLE = 3'd4,
        REG_RANGE_MIN    = 3'd5,
        REG_RANGE_LENGTH = 3'd6
    } cfg_reg_t;

    localparam int          DIV_STEPS  = 18;     // quotient bits of the hash scaling
    localparam logic [3:0]  PRIME_LAST = 4'd11;
    localparam longint      PI_Q30     = 64'sd3373259426;

    localparam logic [31:0] PRIME_A [12] = '{
        32'd15731, 32'd15733, 32'd15737, 32'd15739, 32'd15749, 32'd15761,
        32'd15767, 32'd15773, 32'd15787, 32'd15791, 32'd15797, 32'd15803};
    localparam logic [31:0] PRIME_B [12] = '{
        32'd789221, 32'd789227, 32'd789251, 32'd789311, 32'd789323, 32'd789331,
        32'd789343, 32'd789367, 32'd789377, 32'd789389, 32'd789391, 32'd789407};
    localparam logic [31:0] PRIME_C [12] = '{
        32'd1376312627, 32'd1376312629, 32'd1376312657, 32'd1376312687,
        32'd1376312689, 32'd1376312753, 32'd1376312783, 32'd1376312789,
        32'd1376312813, 32'd1376312857, 32'd1376312879, 32'd1376312881};
    localparam logic [30:0] PRIME_D [12] = '{
        31'd1073741827, 31'd1073741831, 31'd1073741833, 31'd1073741839,
        31'd1073741843, 31'd1073741857, 31'd1073741891, 31'd1073741909,
        31'd1073741939, 31'd1073741953, 31'd1073741969, 31'd1073741971};

    function automatic logic [3:0] clamp_idx(logic [3:0] i);
        return (i > PRIME_LAST) ? PRIME_LAST : i;
    endfunction

    // sin^2(pi*k/2^(bits+1)) by Taylor series in Q2.30, rounded to Q0.16
    function automatic longint sin_sq_half(int k, int bits);
        longint a;
        longint a2;
        longint term;
        longint s;
        a    = (PI_Q30 * longint'(k)) >>> (bits + 1);
        a2   = (a * a) >>> 30;
        term = a;
        s    = a;
        term = ((term * a2) >>> 30) / 6;
        s    = s - term;
        term = ((term * a2) >>> 30) / 20;
        s    = s + term;
        term = ((term * a2) >>> 30) / 42;
        s    = s - term;
        term = ((term * a2) >>> 30) / 72;
        s    = s + term;
        return (((s * s) >>> 30) + 64'sd8192) >>> 14;
    endfunction

    function automatic logic [16:0] ramp_entry(int k, int bits);
        int     n;
        longint v;
        n = 1 << bits;
        if (2 * k > n)
            v = 64'sd65536 - sin_sq_half(n - k, bits);
        else
            v = sin_sq_half(k, bits);
        return v[16:0];
    endfunction

endpackage

// File: src/fvn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn_if
// Handshake channels of the fractal value noise block: sample input, noise
// result and register write.
// ----------------------------------------------------------------------------
interface fvn_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface fvn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] noise_value;
    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

interface fvn_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/fvn_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module fvn_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: src/fvn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvn_div
// Restoring divider, one quotient bit per cycle. Quotient must fit in
// DIV_STEPS bits, i.e. the top of the dividend is below the divisor.
// ----------------------------------------------------------------------------
module fvn_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [17:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [30:0] rem_reg;
    logic [17:0] dvd_reg;
    logic [17:0] q_reg;
    logic [30:0] dvs_reg;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    assign trial = {rem_reg, dvd_reg[17]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(fvn_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend[47:18]};
            dvd_reg <= dividend[17:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[30:0] : trial[30:0];
            dvd_reg <= {dvd_reg[16:0], 1'b0};
            q_reg   <= {q_reg[16:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: src/fractal_value_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// Fractal 2D value noise: per octave sixteen lattice hashes, 3x3 smoothing,
// cosine blend in X then Y, amplitude scaling; optional range mapping.
// ----------------------------------------------------------------------------
// Channel  | Dir | Transaction
// sample   | in  | x_coord, y_coord (unsigned Q16.16)
// result   | out | noise_value (signed Q16.16, saturated)
// cfg      | in  | index, data (register write, always ready)
//
// Each lattice hash takes four multiplier steps and 18 steps of the shared
// restoring divider, which sets the rate. An item runs the octave sequence
// once per summed octave and then the finishing states.
// Reset returns the registers to their defaults and the sequencer to idle.
// sample is ready only when idle; a finished result waits in the output
// register while the next item is accepted and worked on.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d #(
    parameter int MAX_OCTAVES       = 16,
    parameter int COSINE_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    fvn_in_if.sink      sample,
    fvn_out_if.source   result,
    fvn_cfg_if.sink     cfg
);

    localparam int OCT_W = $clog2(MAX_OCTAVES);
    localparam int TAB_N = 1 << COSINE_TABLE_BITS;

    typedef enum logic [17:0] {
        S_IDLE = 18'b000000000000000001,
        S_H0   = 18'b000000000000000010,
        S_H1   = 18'b000000000000000100,
        S_H2   = 18'b000000000000001000,
        S_H3   = 18'b000000000000010000,
        S_H4   = 18'b000000000000100000,
        S_HW   = 18'b000000000001000000,
        S_BX0  = 18'b000000000010000000,
        S_BX1  = 18'b000000000100000000,
        S_BY   = 18'b000000001000000000,
        S_SC   = 18'b000000010000000000,
        S_AMP  = 18'b000000100000000000,
        S_NEXT = 18'b000001000000000000,
        S_FIN  = 18'b000010000000000000,
        S_R0   = 18'b000100000000000000,
        S_R1   = 18'b001000000000000000,
        S_R2   = 18'b010000000000000000,
        S_OUT  = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0]        hash_sel_reg;
    logic [15:0]        pers_reg;
    logic [4:0]         num_oct_reg;
    logic [15:0]        res_stride_reg;
    logic               range_en_reg;
    logic signed [31:0] range_min_reg;
    logic signed [31:0] range_len_reg;

    // datapath
    logic [47:0]        xs_reg;
    logic [47:0]        ys_reg;
    logic [3:0]         pt_reg;
    logic [OCT_W-1:0]   oct_reg;
    logic [31:0]        n_reg;
    logic signed [22:0] s_reg [4];
    logic signed [22:0] s_next [4];
    logic signed [22:0] i1_reg;
    logic [16:0]        amp_reg;
    logic signed [27:0] total_reg;
    logic signed [63:0] plo_reg;
    logic signed [63:0] prod_reg;
    logic signed [43:0] res_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_data_reg;
    logic [16:0]        ramp_f_reg;

    logic [OCT_W-1:0]   oct_count;
    logic [31:0]        ka, kb, kc;
    logic [30:0]        kd;
    logic [31:0]        lat_x, lat_y;
    logic [31:0]        n0, n_c, hsum, csum;
    logic [47:0]        div_dividend;
    logic               div_start, div_done;
    logic [17:0]        div_q;
    logic signed [18:0] h_val;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] p_rnd;
    logic signed [22:0] i2_c, noise_c, d_x0, d_x1, d_y;
    logic signed [27:0] t_c;
    logic [16:0]        ramp_rom [TAB_N];
    logic [15:0]        ramp_frac;
    logic [16:0]        ramp_f;
    logic               accept, out_load;

    for (genvar g = 0; g < TAB_N; g++)
    begin : g_ramp
        assign ramp_rom[g] = fvn_pkg::ramp_entry(g, COSINE_TABLE_BITS);
    end

    // registered table read: the Y weight is fetched in S_BX1 for S_BY
    assign ramp_frac = (state_reg == S_BX1) ? ys_reg[15:0] : xs_reg[15:0];

    always_ff @(posedge clk)
    begin
        ramp_f_reg <= ramp_rom[ramp_frac[15 -: COSINE_TABLE_BITS]];
    end

    assign ramp_f = ramp_f_reg;

    assign ka = fvn_pkg::PRIME_A[fvn_pkg::clamp_idx(hash_sel_reg[3:0])];
    assign kb = fvn_pkg::PRIME_B[fvn_pkg::clamp_idx(hash_sel_reg[7:4])];
    assign kc = fvn_pkg::PRIME_C[fvn_pkg::clamp_idx(hash_sel_reg[11:8])];
    assign kd = fvn_pkg::PRIME_D[fvn_pkg::clamp_idx(hash_sel_reg[15:12])];

    always_comb
    begin
        if (num_oct_reg < 5'd2)
            oct_count = '0;
        else if ((num_oct_reg - 5'd1) > 5'(MAX_OCTAVES - 1))
            oct_count = OCT_W'(MAX_OCTAVES - 1);
        else
            oct_count = OCT_W'(num_oct_reg - 5'd1);
    end

    // lattice point of the 4x4 grid around the sample, offsets -1..2
    assign lat_x = xs_reg[47:16] + {30'd0, pt_reg[1:0]} - 32'd1;
    assign lat_y = ys_reg[47:16] + {30'd0, pt_reg[3:2]} - 32'd1;

    assign n0   = lat_x + mul_p[31:0];
    assign n_c  = n0 ^ {n0[18:0], 13'd0};
    assign hsum = mul_p[31:0] + kb;
    assign csum = mul_p[31:0] + kc;
    assign div_dividend = {1'b0, csum[30:0], 16'd0} + {18'd0, kd[30:1]};
    assign div_start    = (state_reg == S_H4);

    fvn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (kd),
        .done     (div_done),
        .quotient (div_q)
    );

    assign h_val = 19'sd65536 - signed'({1'b0, div_q});

    // each hash feeds every corner whose 3x3 window holds it
    always_comb
    begin
        logic [2:0]         ddx;
        logic [2:0]         ddy;
        logic [1:0]         cc;
        logic [1:0]         sh;
        logic signed [22:0] hx;
        hx = 23'(h_val);
        for (int c = 0; c < 4; c++)
        begin
            cc  = 2'(c);
            ddx = {1'b0, pt_reg[1:0]} - {2'd0, cc[0]};
            ddy = {1'b0, pt_reg[3:2]} - {2'd0, cc[1]};
            sh  = {1'b0, ddx == 3'd1} + {1'b0, ddy == 3'd1};
            if (ddx <= 3'd2 && ddy <= 3'd2)
                s_next[c] = s_reg[c] + (hx <<< sh);
            else
                s_next[c] = s_reg[c];
        end
    end

    assign p_rnd   = (mul_p + 66'sd32768) >>> 16;
    assign d_x0    = s_reg[1] - s_reg[0];
    assign d_x1    = s_reg[3] - s_reg[2];
    assign i2_c    = s_reg[2] + p_rnd[22:0];
    assign d_y     = i2_c - i1_reg;
    assign noise_c = i1_reg + p_rnd[22:0];
    assign t_c     = total_reg + 28'sd1048576;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_H0:
            begin
                mul_a = {1'b0, lat_y};
                mul_b = {17'd0, res_stride_reg};
            end
            S_H1:
            begin
                mul_a = {1'b0, n_c};
                mul_b = {1'b0, n_c};
            end
            S_H2:
            begin
                mul_a = {1'b0, mul_p[31:0]};
                mul_b = {1'b0, ka};
            end
            S_H3:
            begin
                mul_a = {1'b0, n_reg};
                mul_b = {1'b0, hsum};
            end
            S_BX0:
            begin
                mul_a = 33'(d_x0);
                mul_b = {16'd0, ramp_f};
            end
            S_BX1:
            begin
                mul_a = 33'(d_x1);
                mul_b = {16'd0, ramp_f};
            end
            S_BY:
            begin
                mul_a = 33'(d_y);
                mul_b = {16'd0, ramp_f};
            end
            S_SC:
            begin
                mul_a = 33'(noise_c);
                mul_b = {16'd0, amp_reg};
            end
            S_AMP:
            begin
                mul_a = {16'd0, amp_reg};
                mul_b = {17'd0, pers_reg};
            end
            S_FIN:
            begin
                mul_a = 33'(t_c);
                mul_b = {17'd0, range_len_reg[15:0]};
            end
            S_R0:
            begin
                mul_a = 33'(t_c);
                mul_b = {{17{range_len_reg[31]}}, range_len_reg[31:16]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fvn_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign accept   = sample.valid && sample.ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (sample.valid) state_next = (oct_count == '0) ? S_FIN : S_H0;
            S_H0:   state_next = S_H1;
            S_H1:   state_next = S_H2;
            S_H2:   state_next = S_H3;
            S_H3:   state_next = S_H4;
            S_H4:   state_next = S_HW;
            S_HW:   if (div_done) state_next = (pt_reg == 4'd15) ? S_BX0 : S_H0;
            S_BX0:  state_next = S_BX1;
            S_BX1:  state_next = S_BY;
            S_BY:   state_next = S_SC;
            S_SC:   state_next = S_AMP;
            S_AMP:  state_next = S_NEXT;
            S_NEXT: state_next = (oct_reg + OCT_W'(1) == oct_count) ? S_FIN : S_H0;
            S_FIN:  state_next = range_en_reg ? S_R0 : S_OUT;
            S_R0:   state_next = S_R1;
            S_R1:   state_next = S_R2;
            S_R2:   state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            hash_sel_reg   <= 16'd0;
            pers_reg       <= 16'd16384;
            num_oct_reg    <= 5'd6;
            res_stride_reg <= 16'd256;
            range_en_reg   <= 1'b0;
            range_min_reg  <= '0;
            range_len_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    fvn_pkg::REG_HASH_SELECT:  hash_sel_reg   <= cfg.data[15:0];
                    fvn_pkg::REG_PERSISTENCE:  pers_reg       <= cfg.data[15:0];
                    fvn_pkg::REG_NUM_OCTAVES:  num_oct_reg    <= cfg.data[4:0];
                    fvn_pkg::REG_RESOLUTION:   res_stride_reg <= cfg.data[15:0];
                    fvn_pkg::REG_RANGE_ENABLE: range_en_reg   <= cfg.data[0];
                    fvn_pkg::REG_RANGE_MIN:    range_min_reg  <= cfg.data;
                    fvn_pkg::REG_RANGE_LENGTH: range_len_reg  <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xs_reg    <= {16'd0, sample.x_coord};
            ys_reg    <= {16'd0, sample.y_coord};
            pt_reg    <= '0;
            oct_reg   <= '0;
            amp_reg   <= 17'd65536;
            total_reg <= '0;
            for (int c = 0; c < 4; c++)
                s_reg[c] <= '0;
        end
        if (state_reg == S_H1)
            n_reg <= n_c;
        if (state_reg == S_HW && div_done)
        begin
            pt_reg <= pt_reg + 4'd1;
            for (int c = 0; c < 4; c++)
                s_reg[c] <= s_next[c];
        end
        if (state_reg == S_BX1)
            i1_reg <= s_reg[0] + p_rnd[22:0];
        if (state_reg == S_BY)
            i1_reg <= i1_reg;
        if (state_reg == S_AMP)
            total_reg <= total_reg + p_rnd[27:0];
        if (state_reg == S_NEXT)
        begin
            amp_reg <= p_rnd[16:0];
            oct_reg <= oct_reg + OCT_W'(1);
            xs_reg  <= {xs_reg[46:0], 1'b0};
            ys_reg  <= {ys_reg[46:0], 1'b0};
            pt_reg  <= '0;
            for (int c = 0; c < 4; c++)
                s_reg[c] <= '0;
        end
        if (state_reg == S_FIN && !range_en_reg)
            res_reg <= 44'((total_reg + 28'sd8) >>> 4);
        if (state_reg == S_R0)
            plo_reg <= mul_p[63:0];
        if (state_reg == S_R1)
            prod_reg <= (mul_p[63:0] <<< 16) + plo_reg;
        if (state_reg == S_R2)
            res_reg <= 44'(range_min_reg) + 44'((prod_reg + 64'sd1048576) >>> 21);
        if (out_load)
        begin
            if (res_reg > 44'sd2147483647)
                out_data_reg <= 32'sh7fffffff;
            else if (res_reg < -44'sd2147483648)
                out_data_reg <= 32'sh80000000;
            else
                out_data_reg <= res_reg[31:0];
        end
    end

    // i2 and the octave noise are consumed straight from the product register
    assign sample.ready       = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.noise_value = out_data_reg;
    assign cfg.ready          = 1'b1;

endmodule
